// File: hw/rtl/gdc_pkg.sv
`timescale 1ns / 1ps

package gdc_pkg;

    localparam int VERTICES     = 1024;
    localparam int COUNT_BITS   = 16;
    localparam int ADDR_BITS    = $clog2(VERTICES);
    localparam int VID_BITS     = 10;
    localparam int OUT_CNT_BITS = 16;

    typedef logic [ADDR_BITS-1:0]    t_addr;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [VID_BITS-1:0]     t_vid;
    typedef logic [OUT_CNT_BITS-1:0] t_out_count;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_QUERY = 2'd2
    } t_req_type;

    localparam t_count COUNT_MAX = '1;
    localparam t_addr  LAST_ADDR = ADDR_BITS'(VERTICES - 1);

    // second-stage access to one degree store
    typedef struct packed {
        logic  bump;
        t_addr addr;
    } t_bank_upd;

    // clearing sweep control
    typedef struct packed {
        logic  active;
        t_addr addr;
    } t_bank_clr;

    function automatic logic vid_in_range(input t_vid v);
        return 32'(v) < VERTICES;
    endfunction

endpackage

// File: hw/rtl/graph_degree_counter.sv
`timescale 1ns / 1ps

// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+--------------------------
// request  | i_req_type i_src_vertex i_dst_vertex          | start high, busy low
//          | i_query_vertex                                |
// result   | o_vertex_id o_in_count o_out_count            | o_valid, one cycle
//
// one request per cycle while busy is low; a query result is registered in the read stage and then in the result stage.
// edge updates are read-modify-write on the two degree memories, with
// forwarding of the previous cycle's write.
// reset and clear start a sweep that zeroes both memories, one entry per cycle:
// busy stays high after reset or a clear request until the sweep has zeroed entry VERTICES - 1.
// results cannot be held off by the receiver.

module graph_degree_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_req_type,
    input  logic [gdc_pkg::VID_BITS-1:0] i_src_vertex,
    input  logic [gdc_pkg::VID_BITS-1:0] i_dst_vertex,
    input  logic [gdc_pkg::VID_BITS-1:0] i_query_vertex,
    output logic                        o_valid,
    output logic [gdc_pkg::VID_BITS-1:0] o_vertex_id,
    output logic [gdc_pkg::OUT_CNT_BITS-1:0] o_in_count,
    output logic [gdc_pkg::OUT_CNT_BITS-1:0] o_out_count
);

    logic               w_accept;
    logic               w_is_query;
    gdc_pkg::t_addr     w_in_rd_addr;
    gdc_pkg::t_addr     w_out_rd_addr;
    gdc_pkg::t_vid      w_in_vid;
    gdc_pkg::t_vid      w_out_vid;

    logic               r_clr_busy;
    gdc_pkg::t_addr     r_clr_addr;

    logic               r_s1_valid;
    logic [1:0]         r_s1_type;
    gdc_pkg::t_addr     r_s1_in_addr;
    gdc_pkg::t_addr     r_s1_out_addr;
    logic               r_s1_in_ok;
    logic               r_s1_out_ok;
    gdc_pkg::t_vid      r_s1_qv;

    gdc_pkg::t_bank_upd w_in_upd;
    gdc_pkg::t_bank_upd w_out_upd;
    gdc_pkg::t_bank_clr w_clr;
    gdc_pkg::t_count    w_in_count;
    gdc_pkg::t_count    w_out_count;

    logic               w_s1_edge;
    logic               w_s1_query;

    logic                r_o_valid;
    gdc_pkg::t_vid       r_o_vertex_id;
    gdc_pkg::t_out_count r_o_in_count;
    gdc_pkg::t_out_count r_o_out_count;
    logic                n_o_valid;
    gdc_pkg::t_out_count n_o_in_count;
    gdc_pkg::t_out_count n_o_out_count;

    assign busy     = r_clr_busy;
    assign w_accept = start && !r_clr_busy;

    assign w_is_query    = (i_req_type == gdc_pkg::REQ_QUERY);
    assign w_in_vid      = w_is_query ? i_query_vertex : i_dst_vertex;
    assign w_out_vid     = w_is_query ? i_query_vertex : i_src_vertex;
    assign w_in_rd_addr  = gdc_pkg::t_addr'(w_in_vid);
    assign w_out_rd_addr = gdc_pkg::t_addr'(w_out_vid);

    // clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == gdc_pkg::LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + gdc_pkg::t_addr'(1);
        end else if (w_accept && (i_req_type == gdc_pkg::REQ_CLEAR)) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        r_s1_type     <= i_req_type;
        r_s1_in_addr  <= w_in_rd_addr;
        r_s1_out_addr <= w_out_rd_addr;
        r_s1_in_ok    <= gdc_pkg::vid_in_range(w_in_vid);
        r_s1_out_ok   <= gdc_pkg::vid_in_range(w_out_vid);
        r_s1_qv       <= i_query_vertex;
    end

    always_comb begin
        w_s1_edge  = 1'b0;
        w_s1_query = 1'b0;
        case (r_s1_type)
            gdc_pkg::REQ_EDGE: begin
                w_s1_edge = r_s1_valid;
            end
            gdc_pkg::REQ_QUERY: begin
                w_s1_query = r_s1_valid;
            end
            default: begin
                w_s1_edge  = 1'b0;
                w_s1_query = 1'b0;
            end
        endcase
    end

    assign w_in_upd.bump  = w_s1_edge && r_s1_in_ok;
    assign w_in_upd.addr  = r_s1_in_addr;
    assign w_out_upd.bump = w_s1_edge && r_s1_out_ok;
    assign w_out_upd.addr = r_s1_out_addr;
    assign w_clr.active   = r_clr_busy;
    assign w_clr.addr     = r_clr_addr;

    gdc_deg_bank u_in_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_in_rd_addr),
        .i_upd     (w_in_upd),
        .i_clr     (w_clr),
        .o_count   (w_in_count)
    );

    gdc_deg_bank u_out_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_out_rd_addr),
        .i_upd     (w_out_upd),
        .i_clr     (w_clr),
        .o_count   (w_out_count)
    );

    // result stage
    always_comb begin
        n_o_valid     = w_s1_query;
        n_o_in_count  = r_s1_in_ok  ? gdc_pkg::t_out_count'(w_in_count)  : '0;
        n_o_out_count = r_s1_out_ok ? gdc_pkg::t_out_count'(w_out_count) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
        r_o_vertex_id <= r_s1_qv;
        r_o_in_count  <= n_o_in_count;
        r_o_out_count <= n_o_out_count;
    end

    assign o_valid     = r_o_valid;
    assign o_vertex_id = r_o_vertex_id;
    assign o_in_count  = r_o_in_count;
    assign o_out_count = r_o_out_count;

`ifndef SYNTHESIS
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept && w_is_query, 2))
        else $error("result without a query request");

    a_clear_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == gdc_pkg::REQ_CLEAR) |=> busy)
        else $error("clear request did not start the sweep");

    a_no_update_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !w_in_upd.bump && !w_out_upd.bump)
        else $error("degree update during clearing sweep");

    a_sweep_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_busy && $past(r_clr_busy) && $past(i_rst_n))
            |-> r_clr_addr == $past(r_clr_addr) + gdc_pkg::t_addr'(1))
        else $error("clearing sweep skipped an entry");
`endif

endmodule

// File: hw/rtl/gdc_deg_bank.sv
`timescale 1ns / 1ps

module gdc_deg_bank (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gdc_pkg::t_addr     i_rd_addr,
    input  gdc_pkg::t_bank_upd i_upd,
    input  gdc_pkg::t_bank_clr i_clr,
    output gdc_pkg::t_count    o_count
);

    gdc_pkg::t_count r_mem [gdc_pkg::VERTICES];
    gdc_pkg::t_count r_rd_data;

    logic            r_fwd_valid;
    gdc_pkg::t_addr  r_fwd_addr;
    gdc_pkg::t_count r_fwd_data;

    logic            w_hit;
    gdc_pkg::t_count w_cur;
    gdc_pkg::t_count n_count;

    // last cycle's write is not yet visible in the read data
    assign w_hit   = r_fwd_valid && (r_fwd_addr == i_upd.addr);
    assign w_cur   = w_hit ? r_fwd_data : r_rd_data;
    assign o_count = w_cur;

    always_comb begin
        if (w_cur == gdc_pkg::COUNT_MAX) begin
            n_count = w_cur;
        end else begin
            n_count = w_cur + gdc_pkg::t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (i_clr.active) begin
            r_mem[i_clr.addr] <= '0;
        end else if (i_upd.bump) begin
            r_mem[i_upd.addr] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= i_upd.bump && !i_clr.active;
        end
        r_fwd_addr <= i_upd.addr;
        r_fwd_data <= n_count;
    end

endmodule

// File: tb/tb_graph_degree_counter.sv
`timescale 1ns / 1ps

module tb_graph_degree_counter;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1000;
    localparam int         REPEAT_EDGES = 64;

    typedef struct {
        gdc_pkg::t_vid       vid;
        gdc_pkg::t_out_count in_cnt;
        gdc_pkg::t_out_count out_cnt;
    } t_degree_read;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_req_type = gdc_pkg::REQ_CLEAR;
    gdc_pkg::t_vid       i_src_vertex = '0;
    gdc_pkg::t_vid       i_dst_vertex = '0;
    gdc_pkg::t_vid       i_query_vertex = '0;
    logic                o_valid;
    gdc_pkg::t_vid       o_vertex_id;
    gdc_pkg::t_out_count o_in_count;
    gdc_pkg::t_out_count o_out_count;

    gdc_pkg::t_count in_deg [gdc_pkg::VERTICES];
    gdc_pkg::t_count out_deg [gdc_pkg::VERTICES];
    t_degree_read    degree_reads_q [$];
    int              fail_count = 0;
    bit              steady_rate = 1'b0;

    graph_degree_counter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_src_vertex   (i_src_vertex),
        .i_dst_vertex   (i_dst_vertex),
        .i_query_vertex (i_query_vertex),
        .o_valid        (o_valid),
        .o_vertex_id    (o_vertex_id),
        .o_in_count     (o_in_count),
        .o_out_count    (o_out_count)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic clear_degrees();
        for (int v = 0; v < gdc_pkg::VERTICES; v++) begin
            in_deg[v]  = '0;
            out_deg[v] = '0;
        end
    endtask

    task automatic predict_request(input logic [1:0] rt, input gdc_pkg::t_vid src,
                                   input gdc_pkg::t_vid dst, input gdc_pkg::t_vid qv);
        t_degree_read rd;
        case (rt)
            gdc_pkg::REQ_CLEAR: begin
                clear_degrees();
            end
            gdc_pkg::REQ_EDGE: begin
                if (int'(src) < gdc_pkg::VERTICES && out_deg[src] != gdc_pkg::COUNT_MAX)
                    out_deg[src] = out_deg[src] + 1'b1;
                if (int'(dst) < gdc_pkg::VERTICES && in_deg[dst] != gdc_pkg::COUNT_MAX)
                    in_deg[dst] = in_deg[dst] + 1'b1;
            end
            gdc_pkg::REQ_QUERY: begin
                rd.vid     = qv;
                rd.in_cnt  = '0;
                rd.out_cnt = '0;
                if (int'(qv) < gdc_pkg::VERTICES) begin
                    rd.in_cnt  = gdc_pkg::t_out_count'(in_deg[qv]);
                    rd.out_cnt = gdc_pkg::t_out_count'(out_deg[qv]);
                end
                degree_reads_q.push_back(rd);
            end
            default: ;
        endcase
    endtask

    // one request; returns at the edge that accepts it, with start still high
    task automatic send_request(input logic [1:0] rt, input gdc_pkg::t_vid src,
                                input gdc_pkg::t_vid dst, input gdc_pkg::t_vid qv);
        @(negedge i_clk);
        if (!steady_rate) begin
            while ($urandom_range(99) < 28) begin
                start = 1'b0;
                @(negedge i_clk);
            end
        end
        start          = 1'b1;
        i_req_type     = rt;
        i_src_vertex   = src;
        i_dst_vertex   = dst;
        i_query_vertex = qv;
        do @(posedge i_clk); while (busy);
        predict_request(rt, src, dst, qv);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (degree_reads_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic gdc_pkg::t_vid pick_vertex();
        case ($urandom_range(3))
            0: return gdc_pkg::t_vid'($urandom_range(0, 7));
            1: return gdc_pkg::t_vid'(gdc_pkg::VERTICES - 8 + $urandom_range(0, 7));
            default: return gdc_pkg::t_vid'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_degree_read rd;
        if (i_rst_n && o_valid === 1'b1) begin
            if (degree_reads_q.size() == 0) begin
                report_mismatch("unexpected result, vertex", o_vertex_id, -1);
            end else begin
                rd = degree_reads_q.pop_front();
                if (o_vertex_id !== rd.vid)
                    report_mismatch("vertex_id", o_vertex_id, rd.vid);
                if (o_in_count !== rd.in_cnt)
                    report_mismatch("in_count", o_in_count, rd.in_cnt);
                if (o_out_count !== rd.out_cnt)
                    report_mismatch("out_count", o_out_count, rd.out_cnt);
            end
        end
    end

    task automatic test_reset_state();
        send_request(gdc_pkg::REQ_QUERY, '0, '0, '0);
        send_request(gdc_pkg::REQ_QUERY, '1, '1, gdc_pkg::t_vid'(gdc_pkg::VERTICES - 1));
        send_request(gdc_pkg::REQ_QUERY, '0, '1, gdc_pkg::t_vid'(512));
    endtask

    task automatic test_edge_extremes();
        send_request(gdc_pkg::REQ_EDGE, '0, gdc_pkg::t_vid'(gdc_pkg::VERTICES - 1), '1);
        send_request(gdc_pkg::REQ_EDGE, gdc_pkg::t_vid'(gdc_pkg::VERTICES - 1), '0, '0);
        send_request(gdc_pkg::REQ_EDGE, '0, '0, '1);
        send_request(gdc_pkg::REQ_EDGE, gdc_pkg::t_vid'(gdc_pkg::VERTICES - 1),
                     gdc_pkg::t_vid'(gdc_pkg::VERTICES - 1), '0);
        send_request(gdc_pkg::REQ_QUERY, '1, '1, '0);
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(gdc_pkg::VERTICES - 1));
        // back-to-back updates of one vertex then an immediate read
        steady_rate = 1'b1;
        send_request(gdc_pkg::REQ_EDGE, gdc_pkg::t_vid'(3), gdc_pkg::t_vid'(3), '0);
        send_request(gdc_pkg::REQ_EDGE, gdc_pkg::t_vid'(3), gdc_pkg::t_vid'(4), '0);
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(3));
        send_request(gdc_pkg::REQ_EDGE, gdc_pkg::t_vid'(4), gdc_pkg::t_vid'(3),
                     gdc_pkg::t_vid'(3));
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(4));
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(3));
        steady_rate = 1'b0;
        // unused request code changes nothing
        send_request(REQ_UNUSED, gdc_pkg::t_vid'(3), gdc_pkg::t_vid'(3), gdc_pkg::t_vid'(3));
        send_request(REQ_UNUSED, '1, '1, '1);
        send_request(gdc_pkg::REQ_QUERY, '1, '1, gdc_pkg::t_vid'(3));
    endtask

    task automatic test_clear();
        send_request(gdc_pkg::REQ_CLEAR, '1, '1, '1);
        send_request(gdc_pkg::REQ_QUERY, '0, '0, '0);
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(gdc_pkg::VERTICES - 1));
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(3));
    endtask

    task automatic test_repeat_bump();
        steady_rate = 1'b1;
        for (int n = 0; n < REPEAT_EDGES; n++)
            send_request(gdc_pkg::REQ_EDGE, gdc_pkg::t_vid'(10), gdc_pkg::t_vid'(11), '0);
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(10));
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(11));
        send_request(gdc_pkg::REQ_EDGE, gdc_pkg::t_vid'(11), gdc_pkg::t_vid'(10), '0);
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(10));
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(11));
        send_request(gdc_pkg::REQ_CLEAR, '0, '0, '0);
        send_request(gdc_pkg::REQ_QUERY, '0, '0, gdc_pkg::t_vid'(10));
        steady_rate = 1'b0;
    endtask

    task automatic test_random_stream();
        int         roll;
        logic [1:0] rt;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady_rate = (i >= 300 && i < 550);
            if (i == 700)
                wait_results_drained();
            roll = $urandom_range(99);
            if (roll < 1)
                rt = gdc_pkg::REQ_CLEAR;
            else if (roll < 4)
                rt = REQ_UNUSED;
            else if (roll < 66)
                rt = gdc_pkg::REQ_EDGE;
            else
                rt = gdc_pkg::REQ_QUERY;
            send_request(rt, pick_vertex(), pick_vertex(), pick_vertex());
        end
        steady_rate = 1'b0;
    endtask

    initial begin
        clear_degrees();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_edge_extremes();
        test_clear();
        test_repeat_bump();
        test_random_stream();

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/gdc_pkg.sv
hw/rtl/gdc_deg_bank.sv
hw/rtl/graph_degree_counter.sv
tb/tb_graph_degree_counter.sv
